@@ design/best_fit_free_list_allocator_unit_defines.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on aclk outside reset.
`define BFA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator check failed");
// Next-cycle implication, checked on aclk outside reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define BFA_ASSERT_IMPL(lbl, ante, cons)
`define BFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/bfa_pkg.sv @@
// Shared types and constants of the best-fit free-list allocator.
package bfa_pkg;

    localparam int HEAP_START_RST = 2048;
    localparam int HEAP_END_RST   = 16384;
    localparam int ENTRIES_W      = 7;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_END   = 1'b1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_BOOT,
        DP_LOAD,
        DP_REBUILD,
        DP_SCAN_INIT,
        DP_SCAN_RD,
        DP_SCAN_CMP,
        DP_NOFIT,
        DP_SHIFT_INIT,
        DP_SHIFT_RD,
        DP_SHIFT_WR,
        DP_APPEND,
        DP_FULL,
        DP_PUSH,
        DP_SORT_RDI,
        DP_SORT_LDI,
        DP_SORT_RDJ,
        DP_SORT_CMP,
        DP_SORT_WRI,
        DP_MRG_RD0,
        DP_MRG_LD0,
        DP_MRG_RDJ,
        DP_MRG_CMP,
        DP_MRG_FIN,
        DP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       scan_done;
        logic       found;
        logic       i_last;
        logic       j_done;
        logic       full;
        logic       out_busy;
    } dp_status_t;

endpackage

@@ design/bfa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/bfa_ctrl.sv @@
// Sequencer that steps the datapath through allocate, free and reinit.
module bfa_ctrl import bfa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [21:0] {
        S_BOOT     = 22'd1 << 0,
        S_IDLE     = 22'd1 << 1,
        S_DECODE   = 22'd1 << 2,
        S_SCAN_RD  = 22'd1 << 3,
        S_SCAN_CMP = 22'd1 << 4,
        S_SHIFT_RD = 22'd1 << 5,
        S_SHIFT_WR = 22'd1 << 6,
        S_APPEND   = 22'd1 << 7,
        S_PUSH     = 22'd1 << 8,
        S_SORT_RDI = 22'd1 << 9,
        S_SORT_LDI = 22'd1 << 10,
        S_SORT_RDJ = 22'd1 << 11,
        S_SORT_CMP = 22'd1 << 12,
        S_SORT_WRI = 22'd1 << 13,
        S_MRG_RD0  = 22'd1 << 14,
        S_MRG_LD0  = 22'd1 << 15,
        S_MRG_RDJ  = 22'd1 << 16,
        S_MRG_CMP  = 22'd1 << 17,
        S_MRG_FIN  = 22'd1 << 18,
        S_REBUILD  = 22'd1 << 19,
        S_FINISH   = 22'd1 << 20,
        S_SPARE    = 22'd1 << 21
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            S_BOOT: begin
                cmd.op     = DP_BOOT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.mode)
                    MODE_ALLOC: begin
                        cmd.op     = DP_SCAN_INIT;
                        state_next = S_SCAN_RD;
                    end
                    MODE_FREE: begin
                        if (stat.full) begin
                            cmd.op     = DP_FULL;
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_PUSH;
                        end
                    end
                    MODE_REINIT: state_next = S_REBUILD;
                    default:     state_next = S_FINISH;
                endcase
            end
            S_SCAN_RD: begin
                if (!stat.scan_done) begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end else if (stat.found) begin
                    cmd.op     = DP_SHIFT_INIT;
                    state_next = S_SHIFT_RD;
                end else begin
                    cmd.op     = DP_NOFIT;
                    state_next = S_FINISH;
                end
            end
            S_SCAN_CMP: begin
                cmd.op     = DP_SCAN_CMP;
                state_next = S_SCAN_RD;
            end
            S_SHIFT_RD: begin
                if (stat.i_last) begin
                    state_next = S_APPEND;
                end else begin
                    cmd.op     = DP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.op     = DP_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            S_APPEND: begin
                cmd.op     = DP_APPEND;
                state_next = S_FINISH;
            end
            S_PUSH: begin
                cmd.op     = DP_PUSH;
                state_next = S_SORT_RDI;
            end
            S_SORT_RDI: begin
                if (stat.i_last) begin
                    state_next = S_MRG_RD0;
                end else begin
                    cmd.op     = DP_SORT_RDI;
                    state_next = S_SORT_LDI;
                end
            end
            S_SORT_LDI: begin
                cmd.op     = DP_SORT_LDI;
                state_next = S_SORT_RDJ;
            end
            S_SORT_RDJ: begin
                if (stat.j_done) begin
                    state_next = S_SORT_WRI;
                end else begin
                    cmd.op     = DP_SORT_RDJ;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                cmd.op     = DP_SORT_CMP;
                state_next = S_SORT_RDJ;
            end
            S_SORT_WRI: begin
                cmd.op     = DP_SORT_WRI;
                state_next = S_SORT_RDI;
            end
            S_MRG_RD0: begin
                cmd.op     = DP_MRG_RD0;
                state_next = S_MRG_LD0;
            end
            S_MRG_LD0: begin
                cmd.op     = DP_MRG_LD0;
                state_next = S_MRG_RDJ;
            end
            S_MRG_RDJ: begin
                if (stat.j_done) begin
                    state_next = S_MRG_FIN;
                end else begin
                    cmd.op     = DP_MRG_RDJ;
                    state_next = S_MRG_CMP;
                end
            end
            S_MRG_CMP: begin
                cmd.op     = DP_MRG_CMP;
                state_next = S_MRG_RDJ;
            end
            S_MRG_FIN: begin
                cmd.op     = DP_MRG_FIN;
                state_next = S_FINISH;
            end
            S_REBUILD: begin
                cmd.op     = DP_REBUILD;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.op     = DP_RESP;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/bfa_dpath.sv @@
// Extent list storage, counters, compare logic and result register.
module bfa_dpath import bfa_pkg::*; #(
    parameter int LIST_DEPTH = 64,
    parameter int ADDR_BITS  = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [ADDR_BITS:0]   cfg_wdata,
    input  logic [1:0]           in_mode,
    input  logic [ADDR_BITS:0]   in_req_size,
    input  logic [ADDR_BITS-1:0] in_free_start,
    input  dp_cmd_t              cmd,
    output dp_status_t           stat,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [ADDR_BITS-1:0] out_alloc_addr,
    output logic [1:0]           out_status,
    output logic [ENTRIES_W-1:0] out_free_entries
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = ADDR_BITS + 1;
    localparam int EW = ADDR_BITS + SW;

    logic [ADDR_BITS-1:0] hs_reg, hs_next;
    logic [SW-1:0]        he_reg, he_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic [CW-1:0]        best_idx_reg, best_idx_next;
    logic [1:0]           mode_reg, mode_next;
    logic [SW-1:0]        req_reg, req_next;
    logic [ADDR_BITS-1:0] fs_reg, fs_next;
    logic [SW-1:0]        best_size_reg, best_size_next;
    logic [ADDR_BITS-1:0] best_start_reg, best_start_next;
    logic                 found_reg, found_next;
    logic [ADDR_BITS-1:0] cur_start_reg, cur_start_next;
    logic [SW-1:0]        cur_size_reg, cur_size_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 valid_reg, valid_next;
    logic [ADDR_BITS-1:0] oaddr_reg, oaddr_next;
    logic [1:0]           ostat_reg, ostat_next;
    logic [ENTRIES_W-1:0] oent_reg, oent_next;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [ADDR_BITS-1:0] rd_start;
    logic [SW-1:0]        rd_size;
    logic [SW:0]          end_addr;
    logic [SW:0]          size_sum;
    logic [CW-1:0]        cnt_dec;

    assign rd_start = rdata[ADDR_BITS-1:0];
    assign rd_size  = rdata[EW-1:ADDR_BITS];
    assign end_addr = {2'b00, cur_start_reg} + {1'b0, cur_size_reg};
    assign size_sum = {1'b0, cur_size_reg} + {1'b0, rd_size};
    assign cnt_dec  = cnt_reg - CW'(1);

    bfa_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_list (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        stat.mode      = mode_reg;
        stat.scan_done = (i_reg >= cnt_reg);
        stat.found     = found_reg;
        stat.i_last    = ({1'b0, i_reg} + (CW+1)'(1)) >= {1'b0, cnt_reg};
        stat.j_done    = (j_reg >= cnt_reg);
        stat.full      = (cnt_reg >= CW'(LIST_DEPTH));
        stat.out_busy  = valid_reg && !m_tready;
    end

    always_comb begin
        hs_next         = hs_reg;
        he_next         = he_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        w_next          = w_reg;
        best_idx_next   = best_idx_reg;
        mode_next       = mode_reg;
        req_next        = req_reg;
        fs_next         = fs_reg;
        best_size_next  = best_size_reg;
        best_start_next = best_start_reg;
        found_next      = found_reg;
        cur_start_next  = cur_start_reg;
        cur_size_next   = cur_size_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        valid_next      = valid_reg && !m_tready;
        oaddr_next      = oaddr_reg;
        ostat_next      = ostat_reg;
        oent_next       = oent_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = {cur_size_reg, cur_start_reg};
        raddr           = i_reg[AW-1:0];

        if (cfg_we) begin
            if (cfg_addr == REG_HEAP_START) begin
                hs_next = cfg_wdata[ADDR_BITS-1:0];
            end else begin
                he_next = cfg_wdata;
            end
        end

        case (cmd.op)
            DP_BOOT: begin
                // Rebuild from the reset values, not from the live registers.
                we       = 1'b1;
                wdata    = {SW'(HEAP_END_RST) > {1'b0, ADDR_BITS'(HEAP_START_RST)} ?
                            SW'(HEAP_END_RST) - {1'b0, ADDR_BITS'(HEAP_START_RST)} :
                            SW'(0), ADDR_BITS'(HEAP_START_RST)};
                cnt_next = CW'(1);
            end
            DP_REBUILD: begin
                we       = 1'b1;
                wdata    = {he_reg > {1'b0, hs_reg} ? he_reg - {1'b0, hs_reg} : SW'(0),
                            hs_reg};
                cnt_next = CW'(1);
            end
            DP_LOAD: begin
                mode_next       = in_mode;
                req_next        = in_req_size;
                fs_next         = in_free_start;
                res_addr_next   = '0;
                res_status_next = ST_OK;
            end
            DP_SCAN_INIT: begin
                i_next         = '0;
                best_size_next = he_reg;
                found_next     = 1'b0;
            end
            DP_SCAN_RD: raddr = i_reg[AW-1:0];
            DP_SCAN_CMP: begin
                if (rd_size >= req_reg && rd_size < best_size_reg) begin
                    best_size_next  = rd_size;
                    best_start_next = rd_start;
                    best_idx_next   = i_reg;
                    found_next      = 1'b1;
                end
                i_next = i_reg + CW'(1);
            end
            DP_NOFIT:      res_status_next = ST_NOFIT;
            DP_SHIFT_INIT: i_next = best_idx_reg;
            DP_SHIFT_RD:   raddr = AW'(i_reg + CW'(1));
            DP_SHIFT_WR: begin
                we     = 1'b1;
                waddr  = i_reg[AW-1:0];
                wdata  = rdata;
                i_next = i_reg + CW'(1);
            end
            DP_APPEND: begin
                res_addr_next = best_start_reg;
                if (best_size_reg > req_reg) begin
                    we       = 1'b1;
                    waddr    = cnt_dec[AW-1:0];
                    wdata    = {best_size_reg - req_reg,
                                best_start_reg + req_reg[ADDR_BITS-1:0]};
                    cnt_next = cnt_reg;
                end else begin
                    cnt_next = cnt_dec;
                end
            end
            DP_FULL: res_status_next = ST_FULL;
            DP_PUSH: begin
                we       = 1'b1;
                waddr    = cnt_reg[AW-1:0];
                wdata    = {req_reg, fs_reg};
                cnt_next = cnt_reg + CW'(1);
                i_next   = '0;
            end
            DP_SORT_RDI: raddr = i_reg[AW-1:0];
            DP_SORT_LDI: begin
                cur_start_next = rd_start;
                cur_size_next  = rd_size;
                j_next         = i_reg + CW'(1);
            end
            DP_SORT_RDJ: raddr = j_reg[AW-1:0];
            DP_SORT_CMP: begin
                if (cur_start_reg > rd_start) begin
                    we             = 1'b1;
                    waddr          = j_reg[AW-1:0];
                    cur_start_next = rd_start;
                    cur_size_next  = rd_size;
                end
                j_next = j_reg + CW'(1);
            end
            DP_SORT_WRI: begin
                we     = 1'b1;
                waddr  = i_reg[AW-1:0];
                i_next = i_reg + CW'(1);
            end
            DP_MRG_RD0: raddr = '0;
            DP_MRG_LD0: begin
                cur_start_next = rd_start;
                cur_size_next  = rd_size;
                j_next         = CW'(1);
                w_next         = '0;
            end
            DP_MRG_RDJ: raddr = j_reg[AW-1:0];
            DP_MRG_CMP: begin
                if (end_addr == {2'b00, rd_start}) begin
                    // Touching neighbor folds in; the size saturates.
                    cur_size_next = size_sum[SW] ? {SW{1'b1}} : size_sum[SW-1:0];
                end else begin
                    we             = 1'b1;
                    waddr          = w_reg[AW-1:0];
                    w_next         = w_reg + CW'(1);
                    cur_start_next = rd_start;
                    cur_size_next  = rd_size;
                end
                j_next = j_reg + CW'(1);
            end
            DP_MRG_FIN: begin
                we       = 1'b1;
                waddr    = w_reg[AW-1:0];
                cnt_next = w_reg + CW'(1);
            end
            DP_RESP: begin
                valid_next = 1'b1;
                oaddr_next = res_addr_reg;
                ostat_next = res_status_reg;
                oent_next  = ENTRIES_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg    <= ADDR_BITS'(HEAP_START_RST);
            he_reg    <= SW'(HEAP_END_RST);
            cnt_reg   <= CW'(1);
            valid_reg <= 1'b0;
            mode_reg  <= MODE_ALLOC;
        end else begin
            hs_reg    <= hs_next;
            he_reg    <= he_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
        end
        i_reg          <= i_next;
        j_reg          <= j_next;
        w_reg          <= w_next;
        best_idx_reg   <= best_idx_next;
        req_reg        <= req_next;
        fs_reg         <= fs_next;
        best_size_reg  <= best_size_next;
        best_start_reg <= best_start_next;
        found_reg      <= found_next;
        cur_start_reg  <= cur_start_next;
        cur_size_reg   <= cur_size_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        oaddr_reg      <= oaddr_next;
        ostat_reg      <= ostat_next;
        oent_reg       <= oent_next;
    end

    assign m_tvalid         = valid_reg;
    assign out_alloc_addr   = oaddr_reg;
    assign out_status       = ostat_reg;
    assign out_free_entries = oent_reg;

endmodule

@@ design/best_fit_free_list_allocator_unit.sv @@
// Top level of the best-fit free-list allocator with coalescing.
//
// Requests arrive on the s_ stream: s_tuser carries the mode (allocate, free,
// reinitialize, or no operation) and s_tdata the size and the freed start.
// Every request yields exactly one response on the m_ stream: m_tuser holds
// the status and m_tdata the allocated start and the number of free extents.
// The user sets the heap bounds through the cfg_ write port while the block is
// idle; the block itself does not enforce this.
// One request is processed at a time. An allocate reads and compares each of
// the N extents, then shifts every entry behind the picked one down by one
// place. A free runs an exchange sort over the list held in a single-port-read
// RAM, followed by a merge pass. Reinitialize rewrites the list as one extent
// and a no-op only returns a response. The list RAM read is registered, so
// each entry step issues a read and then uses its data.
//
// After reset the block writes the initial extent in its boot state, then
// raises s_tready. A finished response sits in an output register; when the
// receiver stalls, the next request is still accepted and processed, and only
// its own response waits until the register drains.
`include "best_fit_free_list_allocator_unit_defines.svh"
module best_fit_free_list_allocator_unit import bfa_pkg::*; #(
    parameter int LIST_DEPTH = 64,
    parameter int ADDR_BITS  = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [ADDR_BITS:0]   cfg_wdata,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: req_size, free_start (lowest bits first), zero padded.
    input  logic [((2*ADDR_BITS+8)/8)*8-1:0] s_tdata,
    // tuser: mode.
    input  logic [1:0]           s_tuser,
    // Response stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: alloc_addr, free_entries (lowest bits first), zero padded.
    output logic [((ADDR_BITS+ENTRIES_W+7)/8)*8-1:0] m_tdata,
    // tuser: status.
    output logic [1:0]           m_tuser
);

    localparam int OW = ((ADDR_BITS + ENTRIES_W + 7) / 8) * 8;

    dp_cmd_t              cmd;
    dp_status_t           stat;
    logic [ADDR_BITS-1:0] alloc_addr;
    logic [ENTRIES_W-1:0] free_entries;

    // The controller only sequences; all list state lives in the datapath.
    bfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfa_dpath #(.LIST_DEPTH(LIST_DEPTH), .ADDR_BITS(ADDR_BITS)) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_mode          (s_tuser),
        .in_req_size      (s_tdata[ADDR_BITS:0]),
        .in_free_start    (s_tdata[2*ADDR_BITS:ADDR_BITS+1]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_alloc_addr   (alloc_addr),
        .out_status       (m_tuser),
        .out_free_entries (free_entries)
    );

    assign m_tdata = OW'({free_entries, alloc_addr});

    // A failed allocate or a rejected free never reports an address.
    `BFA_ASSERT_IMPL(a_fail_no_addr, m_tvalid && m_tuser != ST_OK, alloc_addr == '0)
    // A rejected free only happens when the list is completely full.
    `BFA_ASSERT_IMPL(a_full_count, m_tvalid && m_tuser == ST_FULL,
                     free_entries == ENTRIES_W'(LIST_DEPTH))
    // Requests are taken one at a time: acceptance drops ready next cycle.
    `BFA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

@@ sim/tb_best_fit_free_list_allocator_unit.sv @@
// Self-checking testbench of the best-fit free-list allocator with coalescing.
module tb_best_fit_free_list_allocator_unit;
    import bfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int ITEMS_PER_PHASE = 200;

    // One response of the block, as the predictor sees it.
    typedef struct {
        logic [13:0] addr;
        logic [1:0]  status;
        logic [6:0]  entries;
    } alloc_rsp_t;

    // One row of the directed table; known rows carry their expected response.
    typedef struct {
        logic [1:0]  mode;
        logic [14:0] size;
        logic [13:0] fstart;
        bit          known;
        alloc_rsp_t  rsp;
    } directed_row_t;

    // A live allocation, kept so that it can be freed again later.
    typedef struct {
        logic [13:0] start;
        logic [14:0] size;
    } extent_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    best_fit_free_list_allocator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // Shadow copy of the block's state and heap bounds.
    int          heap_lo;
    int          heap_hi;
    int          ext_start [DEPTH];
    int          ext_size [DEPTH];
    int          ext_count;

    alloc_rsp_t  pending_rsp [$];
    extent_t     held [$];
    int          errors = 0;
    longint      cycles = 0;
    bit          calm = 1'b0;

    // The list is rebuilt as one extent spanning the configured heap.
    function automatic void rebuild_list();
        ext_count = 1;
        ext_start[0] = heap_lo;
        ext_size[0] = (heap_hi > heap_lo) ? heap_hi - heap_lo : 0;
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < ext_count; i++) begin
            ext_start[i] = ext_start[i + 1];
            ext_size[i] = ext_size[i + 1];
        end
        ext_count--;
    endfunction

    // Computes the response of one request and updates the shadow list.
    function automatic alloc_rsp_t allocator_response(logic [1:0] mode, int size, int fstart);
        alloc_rsp_t r;
        int best_size;
        int best;
        bit found;
        int st;
        int sz;
        int t;
        int i;
        r.addr = '0;
        r.status = ST_OK;
        if (mode == MODE_ALLOC) begin
            best_size = heap_hi;
            best = 0;
            found = 1'b0;
            for (int k = 0; k < ext_count; k++) begin
                if (ext_size[k] >= size && ext_size[k] < best_size) begin
                    best_size = ext_size[k];
                    best = k;
                    found = 1'b1;
                end
            end
            if (!found) begin
                r.status = ST_NOFIT;
            end else begin
                st = ext_start[best];
                sz = ext_size[best];
                drop_entry(best);
                // The leftover goes to the tail; its start wraps at the address width.
                if (sz > size) begin
                    ext_start[ext_count] = (st + size) & 16'h3FFF;
                    ext_size[ext_count] = sz - size;
                    ext_count++;
                end
                r.addr = st[13:0];
            end
        end else if (mode == MODE_FREE) begin
            if (ext_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                ext_start[ext_count] = fstart;
                ext_size[ext_count] = size;
                ext_count++;
                for (int a = 0; a + 1 < ext_count; a++) begin
                    for (int b = a + 1; b < ext_count; b++) begin
                        if (ext_start[a] > ext_start[b]) begin
                            t = ext_start[a]; ext_start[a] = ext_start[b]; ext_start[b] = t;
                            t = ext_size[a]; ext_size[a] = ext_size[b]; ext_size[b] = t;
                        end
                    end
                end
                // Neighbors that touch are merged; the merged size saturates.
                i = 0;
                while (i + 1 < ext_count) begin
                    if (ext_start[i] + ext_size[i] == ext_start[i + 1]) begin
                        t = ext_size[i] + ext_size[i + 1];
                        ext_size[i] = (t > 32767) ? 32767 : t;
                        drop_entry(i + 1);
                    end else begin
                        i++;
                    end
                end
            end
        end else if (mode == MODE_REINIT) begin
            rebuild_list();
        end
        r.entries = ext_count[6:0];
        return r;
    endfunction

    // Response checker: every response is matched against the oldest prediction.
    always @(posedge aclk) begin
        alloc_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response addr=%0d status=%0d entries=%0d",
                         $time, m_tdata[13:0], m_tuser, m_tdata[20:14]);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_tdata[13:0] !== want.addr) begin
                    $display("%0t: alloc_addr expected %0d actual %0d",
                             $time, want.addr, m_tdata[13:0]);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[20:14] !== want.entries) begin
                    $display("%0t: free_entries expected %0d actual %0d",
                             $time, want.entries, m_tdata[20:14]);
                    errors++;
                end
            end
        end
    end

    // The receiver stalls in runs: mostly short, sometimes long, none while calm.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Sends one request and records its expected response once it is accepted.
    // A known response from the directed table replaces the predicted one.
    task automatic send_request(logic [1:0] mode, logic [14:0] size, logic [13:0] fstart,
                                bit known, alloc_rsp_t known_rsp);
        int gap;
        alloc_rsp_t r;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {3'b000, fstart, size};
        do @(posedge aclk); while (!s_tready);
        r = allocator_response(mode, size, fstart);
        if (mode == MODE_ALLOC && r.status == ST_OK && size != 0)
            held.push_back('{start: r.addr, size: size});
        if (mode == MODE_REINIT) held.delete();
        pending_rsp.push_back(known ? known_rsp : r);
    endtask

    task automatic send_plain(logic [1:0] mode, logic [14:0] size, logic [13:0] fstart);
        alloc_rsp_t none;
        none = '{addr: '0, status: ST_OK, entries: '0};
        send_request(mode, size, fstart, 1'b0, none);
    endtask

    // Register writes happen only once the block has drained its responses.
    task automatic write_heap(logic [13:0] lo, logic [14:0] hi);
        s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_HEAP_START;
        cfg_wdata <= {1'b0, lo};
        @(posedge aclk);
        cfg_addr <= REG_HEAP_END;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we <= 1'b0;
        heap_lo = lo;
        heap_hi = hi;
    endtask

    // Frees single words at spread-out addresses until the list is full, then one
    // more free, which must be refused, an allocate, another free and a reinit.
    task automatic fill_list();
        int k;
        k = $urandom_range(0, 50);
        while (ext_count < DEPTH) begin
            send_plain(MODE_FREE, 15'd1, 14'((k * 2) & 16'h3FFF));
            k = k + 3;
        end
        send_plain(MODE_FREE, 15'($urandom_range(0, 32767)), 14'($urandom_range(0, 16383)));
        send_plain(MODE_ALLOC, 15'd1, '0);
        send_plain(MODE_FREE, 15'd5, 14'd3);
        send_plain(MODE_REINIT, '0, '0);
    endtask

    // Random traffic: mostly allocations and frees of live extents.
    task automatic random_phase(int n);
        int pick;
        int idx;
        extent_t e;
        logic [14:0] sz;
        for (int k = 0; k < n; k++) begin
            if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 9))
                    0: sz = '0;
                    1: sz = 15'($urandom_range(0, 32767));
                    2: sz = 15'($urandom_range(0, heap_hi));
                    default: sz = 15'($urandom_range(1, 300));
                endcase
                send_plain(MODE_ALLOC, sz, 14'($urandom_range(0, 16383)));
            end else if (pick < 85 && held.size() != 0) begin
                idx = $urandom_range(0, held.size() - 1);
                e = held[idx];
                held.delete(idx);
                send_plain(MODE_FREE, e.size, e.start);
            end else if (pick < 92) begin
                send_plain(MODE_FREE, 15'($urandom_range(0, 32767)),
                           14'($urandom_range(0, 16383)));
            end else if (pick < 95) begin
                send_plain(MODE_REINIT, 15'($urandom_range(0, 32767)),
                           14'($urandom_range(0, 16383)));
            end else if (pick < 99) begin
                send_plain(MODE_NOP, 15'($urandom_range(0, 32767)),
                           14'($urandom_range(0, 16383)));
            end else begin
                fill_list();
            end
            // Keep the list short so that sorting does not dominate the run.
            if (ext_count > 24) send_plain(MODE_REINIT, '0, '0);
        end
        calm = 1'b0;
    endtask

    directed_row_t directed [16];

    initial begin
        directed[0]  = '{MODE_NOP,    15'd0,     14'd0,     1, '{14'd0,    ST_OK,    7'd1}};
        directed[1]  = '{MODE_ALLOC,  15'd16384, 14'd0,     1, '{14'd0,    ST_NOFIT, 7'd1}};
        directed[2]  = '{MODE_ALLOC,  15'd32767, 14'd16383, 1, '{14'd0,    ST_NOFIT, 7'd1}};
        directed[3]  = '{MODE_ALLOC,  15'd0,     14'd0,     1, '{14'd2048, ST_OK,    7'd1}};
        directed[4]  = '{MODE_ALLOC,  15'd100,   14'd0,     1, '{14'd2048, ST_OK,    7'd1}};
        directed[5]  = '{MODE_FREE,   15'd100,   14'd2048,  1, '{14'd0,    ST_OK,    7'd1}};
        directed[6]  = '{MODE_FREE,   15'd0,     14'd0,     0, '{14'd0,    ST_OK,    7'd0}};
        directed[7]  = '{MODE_REINIT, 15'd0,     14'd0,     1, '{14'd0,    ST_OK,    7'd1}};
        directed[8]  = '{MODE_ALLOC,  15'd14336, 14'd0,     1, '{14'd2048, ST_OK,    7'd0}};
        directed[9]  = '{MODE_ALLOC,  15'd1,     14'd0,     1, '{14'd0,    ST_NOFIT, 7'd0}};
        directed[10] = '{MODE_FREE,   15'd10,    14'd16380, 1, '{14'd0,    ST_OK,    7'd1}};
        // The leftover of this allocation wraps to address zero.
        directed[11] = '{MODE_ALLOC,  15'd4,     14'd0,     0, '{14'd0,    ST_OK,    7'd0}};
        directed[12] = '{MODE_FREE,   15'd32767, 14'd16383, 0, '{14'd0,    ST_OK,    7'd0}};
        // Merging with a maximal extent saturates the size.
        directed[13] = '{MODE_FREE,   15'd32767, 14'd6,     0, '{14'd0,    ST_OK,    7'd0}};
        directed[14] = '{MODE_ALLOC,  15'd5,     14'd0,     0, '{14'd0,    ST_OK,    7'd0}};
        directed[15] = '{MODE_REINIT, 15'd0,     14'd0,     1, '{14'd0,    ST_OK,    7'd1}};

        heap_lo = HEAP_START_RST;
        heap_hi = HEAP_END_RST;
        rebuild_list();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_request(directed[i].mode, directed[i].size, directed[i].fstart,
                         directed[i].known, directed[i].rsp);
        fill_list();
        random_phase(ITEMS_PER_PHASE);

        // Widest heap, inverted bounds, a small heap, then a random one.
        write_heap(14'd0, 15'd16384);
        send_plain(MODE_REINIT, '0, '0);
        random_phase(ITEMS_PER_PHASE);
        write_heap(14'd16383, 15'd1);
        send_plain(MODE_REINIT, '0, '0);
        send_plain(MODE_ALLOC, 15'd0, '0);
        send_plain(MODE_FREE, 15'd50, 14'd16383);
        random_phase(100);
        write_heap(14'd100, 15'd612);
        send_plain(MODE_REINIT, '0, '0);
        random_phase(ITEMS_PER_PHASE);
        write_heap(14'($urandom_range(0, 8191)), 15'($urandom_range(8192, 16384)));
        send_plain(MODE_REINIT, '0, '0);
        random_phase(ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
